// File: rtl/jse_pkg.sv
// jse_pkg: shared types and character constants of the json string escaper
// no dependencies; used by the interfaces and all rtl modules

package jse_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned ESC_MAX = 6;
  localparam int unsigned CNT_W  = $clog2(ESC_MAX + 1);

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // characters used by the escapes
  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_BS     = 8'h08;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_LOW_A  = 8'h61;
  localparam char_t CH_LOW_B  = 8'h62;
  localparam char_t CH_LOW_F  = 8'h66;
  localparam char_t CH_LOW_N  = 8'h6E;
  localparam char_t CH_LOW_R  = 8'h72;
  localparam char_t CH_LOW_T  = 8'h74;
  localparam char_t CH_LOW_U  = 8'h75;
  localparam char_t CTRL_LIMIT = 8'h20;

  localparam len_t BUF_SIZE_RST = 16'd256;

  // one escape: characters in emission order, seq[0] first
  typedef struct packed {
    char_t [ESC_MAX-1:0] seq;
    cnt_t                n;
  } esc_t;

  // request from the budget stage to the emitter
  typedef struct packed {
    logic valid;
    esc_t esc;
    logic is_end;
    len_t total_len;
  } load_t;

endpackage

// File: rtl/jse_cfg_if.sv
// jse_cfg_if: configuration write channel carrying the buffer size
// depends on jse_pkg

interface jse_cfg_if;
  logic          valid;
  logic          ready;
  jse_pkg::len_t buffer_size;

  modport source(output valid, output buffer_size, input ready);
  modport sink(input valid, input buffer_size, output ready);
endinterface

// File: rtl/jse_in_if.sv
// jse_in_if: input channel, one string byte per request
// depends on jse_pkg

interface jse_in_if;
  logic           valid;
  logic           ready;
  jse_pkg::char_t in_char;

  modport source(output valid, output in_char, input ready);
  modport sink(input valid, input in_char, output ready);
endinterface

// File: rtl/jse_out_if.sv
// jse_out_if: output channel, one escaped character per request
// depends on jse_pkg

interface jse_out_if;
  logic           valid;
  logic           ready;
  jse_pkg::char_t out_char;
  logic           is_end;
  jse_pkg::len_t  total_length;
  logic           last_of_run;

  modport source(output valid, output out_char, output is_end,
                 output total_length, output last_of_run, input ready);
  modport sink(input valid, input out_char, input is_end,
               input total_length, input last_of_run, output ready);
endinterface

// File: rtl/jse_escape_enc.sv
// jse_escape_enc: maps one byte to its json escape sequence and length
// depends on jse_pkg

module jse_escape_enc (
  input  jse_pkg::char_t char_i,
  output jse_pkg::esc_t  esc_o
);
  import jse_pkg::*;

  function automatic char_t hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      hex_digit = CH_ZERO + {4'd0, v};
    end else begin
      hex_digit = CH_LOW_A + {4'd0, v - 4'd10};
    end
  endfunction

  // escape table
  always_comb begin
    esc_o.seq    = '0;
    esc_o.n      = cnt_t'(2);
    esc_o.seq[0] = CH_BSLASH;
    case (char_i)
      CH_QUOTE:  esc_o.seq[1] = CH_QUOTE;
      CH_BSLASH: esc_o.seq[1] = CH_BSLASH;
      CH_BS:     esc_o.seq[1] = CH_LOW_B;
      CH_FF:     esc_o.seq[1] = CH_LOW_F;
      CH_LF:     esc_o.seq[1] = CH_LOW_N;
      CH_CR:     esc_o.seq[1] = CH_LOW_R;
      CH_TAB:    esc_o.seq[1] = CH_LOW_T;
      default: begin
        if (char_i < CTRL_LIMIT) begin
          // other control bytes as \u00xx
          esc_o.seq[1] = CH_LOW_U;
          esc_o.seq[2] = CH_ZERO;
          esc_o.seq[3] = CH_ZERO;
          esc_o.seq[4] = hex_digit(char_i[7:4]);
          esc_o.seq[5] = hex_digit(char_i[3:0]);
          esc_o.n      = cnt_t'(ESC_MAX);
        end else begin
          esc_o.seq[0] = char_i;
          esc_o.n      = cnt_t'(1);
        end
      end
    endcase
  end

endmodule

// File: rtl/jse_emitter.sv
// jse_emitter: holds one escape and sends it out a character per cycle while the output is ready
// depends on jse_pkg and jse_out_if

module jse_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jse_pkg::load_t load_i,
  output logic           free_o,
  jse_out_if.source      out_o
);
  import jse_pkg::*;

  logic                active_q, active_d;
  char_t [ESC_MAX-1:0] seq_q, seq_d;
  cnt_t                n_q, n_d;
  cnt_t                idx_q, idx_d;
  logic                end_q, end_d;
  len_t                len_q, len_d;
  logic                last;

  assign last   = (idx_q == n_q - cnt_t'(1));
  assign free_o = !active_q || (out_o.ready && last);

  // sequence control
  always_comb begin
    active_d = active_q;
    seq_d    = seq_q;
    n_d      = n_q;
    idx_d    = idx_q;
    end_d    = end_q;
    len_d    = len_q;
    if (free_o && load_i.valid) begin
      active_d = 1'b1;
      seq_d    = load_i.esc.seq;
      n_d      = load_i.esc.n;
      idx_d    = '0;
      end_d    = load_i.is_end;
      len_d    = load_i.is_end ? load_i.total_len : '0;
    end else if (active_q && out_o.ready) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      n_q      <= cnt_t'(1);
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    end_q <= end_d;
    len_q <= len_d;
  end

  // output request
  assign out_o.valid        = active_q;
  assign out_o.out_char     = seq_q[idx_q];
  assign out_o.is_end       = end_q;
  assign out_o.total_length = len_q;
  assign out_o.last_of_run  = last;

endmodule

// File: rtl/json_string_escaper_core.sv
// JSON string escaper. Each input request carries one string byte; each
// output request carries one character of its escape. A plain byte gives
// one character, a two-character escape two and a \u00xx escape six, sent
// one per cycle by the emitter while the output is ready; a zero byte gives
// one terminator with the length, and a dropped byte needs no emitter slot.
// A byte passes the input register, then the emitter registers, before its
// first character. The input register holds the next byte while the emitter
// drains a longer escape, so plain text runs at one byte per cycle while the
// output is ready. The user must write buffer_size through the configuration
// channel only while the block is idle; the block does not enforce this.
// depends on jse_pkg, the channel interfaces, jse_escape_enc and jse_emitter

module json_string_escaper_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  jse_cfg_if.sink cfg_i,
  jse_in_if.sink  in_i,
  jse_out_if.source out_o
);
  import jse_pkg::*;

  len_t          buf_size_q;
  logic          in_vld_q, in_vld_d;
  char_t         in_char_q;
  len_t          wr_cnt_q, wr_cnt_d;
  logic          stopped_q, stopped_d;
  esc_t          enc;
  load_t         load;
  logic          free;
  logic          is_zero;
  len_t          budget;
  logic [LEN_W:0] need;
  logic          fits;
  logic          emit;
  logic          take;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= BUF_SIZE_RST;
    end else if (cfg_i.valid) begin
      buf_size_q <= cfg_i.buffer_size;
    end
  end

  // input register
  assign in_i.ready = !in_vld_q || take;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (take) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.in_char;
    end
  end

  jse_escape_enc u_enc (
    .char_i (in_char_q),
    .esc_o  (enc)
  );

  // budget check: the whole escape must fit in buffer_size - 1
  assign is_zero = (in_char_q == CH_NUL);
  assign budget  = (buf_size_q == '0) ? '0 : buf_size_q - len_t'(1);
  assign need    = {1'b0, wr_cnt_q} + {{(LEN_W + 1 - CNT_W){1'b0}}, enc.n};
  assign fits    = (need <= {1'b0, budget});
  assign emit    = is_zero || (!stopped_q && fits);

  // a dropped byte needs no emitter slot
  assign take = in_vld_q && (!emit || free);

  always_comb begin
    wr_cnt_d  = wr_cnt_q;
    stopped_d = stopped_q;
    if (take) begin
      if (is_zero) begin
        wr_cnt_d  = '0;
        stopped_d = 1'b0;
      end else if (!stopped_q) begin
        if (fits) begin
          wr_cnt_d = need[LEN_W-1:0];
        end else begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q  <= '0;
      stopped_q <= 1'b0;
    end else begin
      wr_cnt_q  <= wr_cnt_d;
      stopped_q <= stopped_d;
    end
  end

  // emitter load request
  always_comb begin
    load.valid     = take && emit;
    load.esc       = enc;
    load.is_end    = is_zero;
    load.total_len = wr_cnt_q;
    if (is_zero) begin
      load.esc.seq    = '0;
      load.esc.seq[0] = CH_NUL;
      load.esc.n      = cnt_t'(1);
    end
  end

  jse_emitter u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

// File: rtl/jse_checker.sv
// jse_checker: port-level checks of the escaper output channel
// depends on jse_pkg; bound to json_string_escaper_core

module jse_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input jse_pkg::char_t out_char_i,
  input logic           is_end_i,
  input jse_pkg::len_t  total_length_i,
  input logic           last_of_run_i
);
  import jse_pkg::*;

  // a stalled output request holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(is_end_i) && $stable(total_length_i) && $stable(last_of_run_i))
    else $error("output request changed while stalled");

  // the terminator is a lone zero character
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |-> last_of_run_i && (out_char_i == CH_NUL))
    else $error("terminator not last or not zero");

  // the length is only reported on the terminator
  a_len_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_end_i |-> (total_length_i == '0))
    else $error("length on a non-terminator result");

  // inner characters of an escape are never zero
  a_inner_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> !is_end_i && (out_char_i != CH_NUL))
    else $error("zero inside an escape sequence");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_char_i     (out_o.out_char),
  .is_end_i       (out_o.is_end),
  .total_length_i (out_o.total_length),
  .last_of_run_i  (out_o.last_of_run)
);
